// ===== rtl/att_pkg.sv =====
// Shared types, constants and helper functions for the ANSI text terminal.
// No dependencies; imported by rtl/ansi_text_terminal.sv.
package att_pkg;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = 16;
    localparam int RADDR_W = 11;
    localparam int MODE_W  = 2;
    localparam int PT_W    = 5;
    localparam int PV_W    = 14;

    localparam logic [PV_W-1:0] PARAM_LIMIT = 14'd9999;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_J     = 8'h4A;
    localparam logic [CHAR_W-1:0] CH_M     = 8'h6D;

    localparam logic [ATTR_W-1:0] ATTR_BOLD   = 8'h08;
    localparam logic [ATTR_W-1:0] ATTR_UNDER  = 8'hBB;
    localparam logic [ATTR_W-1:0] ATTR_BLINK  = 8'h80;
    localparam logic [ATTR_W-1:0] DFLT_RESET  = 8'h07;
    localparam logic [ATTR_W-1:0] BLANK_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] INIT_CELL   = 16'h0F20;

    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ESC    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CSI    = 2'd2;

    localparam logic REG_DEFAULT = 1'b0;
    localparam logic REG_BLANK   = 1'b1;

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_SCROLL = 8'b0001_0000,
        S_FILL   = 8'b0010_0000,
        S_SGR    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    function automatic logic [3:0] colour_map(input logic [2:0] c);
        logic [3:0] r;
        case (c)
            3'd0: r = 4'd0;
            3'd1: r = 4'd4;
            3'd2: r = 4'd2;
            3'd3: r = 4'd6;
            3'd4: r = 4'd1;
            3'd5: r = 4'd5;
            3'd6: r = 4'd3;
            default: r = 4'd7;
        endcase
        return r;
    endfunction

    function automatic logic [ATTR_W-1:0] sgr_apply(input logic [ATTR_W-1:0] attr,
                                                   input logic [PV_W-1:0] v,
                                                   input logic [ATTR_W-1:0] dflt);
        logic [ATTR_W-1:0] r;
        r = attr;
        if (v == 14'd0)
            r = dflt;
        else if (v == 14'd1)
            r = attr | ATTR_BOLD;
        else if (v == 14'd4)
            r = attr & ATTR_UNDER;
        else if (v == 14'd5)
            r = attr | ATTR_BLINK;
        else if (v >= 14'd30 && v <= 14'd37)
            r = {attr[7:4], colour_map(3'(v - 14'd30))};
        else if (v >= 14'd40 && v <= 14'd47)
            r = {colour_map(3'(v - 14'd40)), attr[3:0]};
        return r;
    endfunction

endpackage

// ===== rtl/ansi_text_terminal.sv =====
// Character-cell text terminal with ANSI escape parser, cell memory and APB registers.
// Depends on rtl/att_pkg.sv.
//
// Channel   Signals                                         Direction
// in        in_valid/in_stall, kind, char_code, read_address  sink
// out       out_valid/out_stall, cursor_column, cursor_row,
//           read_data, current_attribute, parser_mode        source
// cfg       psel, penable, pwrite, paddr, pwdata, prdata     APB slave
//
// A plain byte passes through accept, execute and result states; a read adds a
// memory read state before the result. An SGR sequence adds an SGR state that
// applies each parameter in turn. Scroll walks the cell memory through its single
// read port, then blanks the bottom row; clear blanks every cell. After reset a
// clearing pass over every cell runs before the first beat is taken.
// in_stall is high while an item is busy or a result waits on out_stall.
module ansi_text_terminal #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int MAX_PARAMS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         kind,
    input  logic [att_pkg::CHAR_W-1:0]   char_code,
    input  logic [att_pkg::RADDR_W-1:0]  read_address,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [att_pkg::COL_W-1:0]    cursor_column,
    output logic [att_pkg::ROW_W-1:0]    cursor_row,
    output logic [att_pkg::CELL_W-1:0]   read_data,
    output logic [att_pkg::ATTR_W-1:0]   current_attribute,
    output logic [att_pkg::MODE_W-1:0]   parser_mode,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import att_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int LAST   = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int PIDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] ram_q;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [PT_W-1:0]   pt_reg, pt_next;
    logic [PV_W-1:0]   pv_reg [MAX_PARAMS];
    logic [PV_W-1:0]   pv_next [MAX_PARAMS];
    logic              kind_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [RADDR_W-1:0] raddr_reg;
    logic [CELL_W-1:0] data_reg, data_next;
    logic [ATTR_W-1:0] dflt_reg, blank_reg;
    logic              out_valid_reg;
    logic [COL_W-1:0]  ocol_reg;
    logic [ROW_W-1:0]  orow_reg;
    logic [CELL_W-1:0] odata_reg;
    logic [ATTR_W-1:0] oattr_reg;
    logic [MODE_W-1:0] omode_reg;

    logic              in_take, out_load, cfg_wr;
    logic [COL_W-1:0]  wcol;
    logic [ROW_W-1:0]  wrow;
    logic [7:0]        tab_col;
    logic [PIDX_W-1:0] pidx;
    logic [PV_W+4-1:0] digit_v;
    logic [PT_W-1:0]   sgr_n;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_BLANK) ? {24'd0, blank_reg} : {24'd0, dflt_reg};
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign out_valid         = out_valid_reg;
    assign cursor_column     = ocol_reg;
    assign cursor_row        = orow_reg;
    assign read_data         = odata_reg;
    assign current_attribute = oattr_reg;
    assign parser_mode       = omode_reg;

    assign tab_col = ({1'b0, col_reg} + 8'd4) & ~8'd3;
    assign pidx    = PIDX_W'(pt_reg - PT_W'(1));
    assign digit_v = (PV_W + 4)'(pv_reg[pidx]) * (PV_W + 4)'(10)
                   + (PV_W + 4)'(char_reg - CH_ZERO);
    assign sgr_n   = (pt_reg > PT_W'(MAX_PARAMS)) ? PT_W'(MAX_PARAMS) : pt_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        ram_q <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        attr_next  = attr_reg;
        mode_next  = mode_reg;
        pt_next    = pt_reg;
        pv_next    = pv_reg;
        data_next  = data_reg;
        mem_we     = 1'b0;
        mem_waddr  = ADDR_W'(cnt_reg);
        mem_raddr  = ADDR_W'(raddr_reg);
        mem_wdata  = {blank_reg, CH_SPACE};
        wcol       = col_reg;
        wrow       = row_reg;
        unique case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = INIT_CELL;
                if (cnt_reg == CNT_W'(CELLS - 1))
                    state_next = S_IDLE;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_IDLE:
            begin
                if (in_take)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                data_next  = '0;
                state_next = S_DONE;
                if (kind_reg)
                begin
                    state_next = S_READ;
                end
                else if (mode_reg == MODE_ESC)
                begin
                    if (char_reg == CH_LBRK)
                    begin
                        mode_next = MODE_CSI;
                        pt_next   = PT_W'(1);
                        for (int i = 0; i < MAX_PARAMS; i++)
                            pv_next[i] = '0;
                    end
                    else
                        mode_next = MODE_NORMAL;
                end
                else if (mode_reg == MODE_CSI)
                begin
                    if (char_reg >= CH_ZERO && char_reg <= CH_NINE)
                    begin
                        if (pt_reg >= PT_W'(1) && pt_reg <= PT_W'(MAX_PARAMS))
                            pv_next[pidx] = (digit_v > (PV_W + 4)'(PARAM_LIMIT))
                                          ? PARAM_LIMIT : PV_W'(digit_v);
                    end
                    else if (char_reg == CH_SEMI)
                    begin
                        if (pt_reg < PT_W'(MAX_PARAMS + 1))
                            pt_next = pt_reg + PT_W'(1);
                    end
                    else
                    begin
                        mode_next = MODE_NORMAL;
                        if (char_reg == CH_M)
                        begin
                            cnt_next   = '0;
                            state_next = S_SGR;
                        end
                        else if (char_reg == CH_J && pv_reg[0] == PV_W'(2))
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            cnt_next   = '0;
                            state_next = S_FILL;
                        end
                    end
                end
                else
                begin
                    case (char_reg)
                        CH_ESC: mode_next = MODE_ESC;
                        CH_NUL, CH_BEL: ;
                        CH_BS:
                        begin
                            if (col_reg != '0)
                                wcol = col_reg - COL_W'(1);
                            else if (row_reg != '0)
                            begin
                                wcol = COL_W'(COLUMNS - 1);
                                wrow = row_reg - ROW_W'(1);
                            end
                            col_next  = wcol;
                            row_next  = wrow;
                            mem_we    = 1'b1;
                            mem_wdata = {attr_reg, CH_SPACE};
                        end
                        CH_LF:
                        begin
                            col_next = '0;
                            row_next = row_reg + ROW_W'(1);
                        end
                        CH_TAB:
                        begin
                            if (tab_col >= 8'(COLUMNS))
                            begin
                                col_next = '0;
                                row_next = row_reg + ROW_W'(1);
                            end
                            else
                                col_next = COL_W'(tab_col);
                        end
                        CH_CR: col_next = '0;
                        default:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {attr_reg, char_reg};
                            if (col_reg + COL_W'(1) >= COL_W'(COLUMNS))
                            begin
                                col_next = '0;
                                row_next = row_reg + ROW_W'(1);
                            end
                            else
                                col_next = col_reg + COL_W'(1);
                        end
                    endcase
                    mem_waddr = ADDR_W'(wrow * ADDR_W'(COLUMNS) + ADDR_W'(wcol));
                    if (row_next == ROW_W'(ROWS))
                    begin
                        row_next   = ROW_W'(ROWS - 1);
                        cnt_next   = '0;
                        state_next = S_SCROLL;
                    end
                end
            end
            S_READ:
            begin
                if ((RADDR_W + 1)'(raddr_reg) < (RADDR_W + 1)'(CELLS))
                    data_next = ram_q;
                state_next = S_DONE;
            end
            S_SCROLL:
            begin
                mem_raddr = ADDR_W'(cnt_reg + CNT_W'(COLUMNS));
                mem_waddr = ADDR_W'(cnt_reg - CNT_W'(1));
                mem_wdata = ram_q;
                mem_we    = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(LAST))
                    state_next = S_FILL;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_FILL:
            begin
                mem_we = 1'b1;
                if (cnt_reg == CNT_W'(CELLS - 1))
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_SGR:
            begin
                if (cnt_reg < CNT_W'(sgr_n))
                begin
                    attr_next = sgr_apply(attr_reg, pv_reg[PIDX_W'(cnt_reg)], dflt_reg);
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= DFLT_RESET;
            mode_reg      <= MODE_NORMAL;
            pt_reg        <= '0;
            for (int i = 0; i < MAX_PARAMS; i++)
                pv_reg[i] <= '0;
            dflt_reg      <= DFLT_RESET;
            blank_reg     <= BLANK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            attr_reg  <= attr_next;
            mode_reg  <= mode_next;
            pt_reg    <= pt_next;
            pv_reg    <= pv_next;
            if (cfg_wr)
            begin
                if (paddr[2] == REG_BLANK)
                    blank_reg <= pwdata[ATTR_W-1:0];
                else
                    dflt_reg <= pwdata[ATTR_W-1:0];
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (in_take)
        begin
            kind_reg  <= kind;
            char_reg  <= char_code;
            raddr_reg <= read_address;
        end
        if (out_load)
        begin
            ocol_reg  <= col_reg;
            orow_reg  <= row_reg;
            odata_reg <= data_reg;
            oattr_reg <= attr_reg;
            omode_reg <= mode_reg;
        end
    end

endmodule

// ===== rtl/att_checker.sv =====
// Port-level checks for the ANSI text terminal, bound to the top level.
// Depends on rtl/ansi_text_terminal.sv.
module att_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [6:0]  cursor_column,
    input logic [4:0]  cursor_row,
    input logic [15:0] read_data,
    input logic [1:0]  parser_mode
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(cursor_row))
        else $error("result beat changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on back-to-back cycles");

    a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cursor_row < 5'(ROWS)) && (cursor_column < 7'(COLUMNS)))
        else $error("cursor outside screen");

    a_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> parser_mode != 2'd3)
        else $error("bad parser mode");

endmodule

bind ansi_text_terminal att_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_att_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cursor_column(cursor_column),
    .cursor_row(cursor_row), .read_data(read_data), .parser_mode(parser_mode)
);
